// ----- hw/rtl/sclp_pkg.sv -----
// Shared constants, types and the tanh table for the soft clipper and peak meter.
`timescale 1ns / 1ps
package sclp_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int TANH_ENTRIES  = 256;
  localparam int TANH_IDX_BITS = $clog2(TANH_ENTRIES);
  localparam int GAIN_BITS     = 16;
  localparam int DRIVE_FRAC    = 12;
  localparam int MASTER_FRAC   = 14;
  localparam int DECAY_FRAC    = 16;
  localparam int ACC_BITS      = SAMPLE_BITS + 4;
  localparam int MST_BITS      = SAMPLE_BITS + 2;
  localparam int PROD_BITS     = 2 * SAMPLE_BITS;
  localparam int IDX_SHIFT     = SAMPLE_BITS + 1 - TANH_IDX_BITS;
  localparam int THR_SHIFT     = SAMPLE_BITS - GAIN_BITS;
  localparam int QDEPTH        = 2;
  localparam int QPTR_BITS     = $clog2(QDEPTH);
  localparam int QCNT_BITS     = $clog2(QDEPTH + 1);

  localparam logic [SAMPLE_BITS-1:0] S_ONE      = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [GAIN_BITS-1:0]   DECAY_Q16  = 16'd62259;
  localparam logic [GAIN_BITS-1:0]   THR_UNITY  = 16'd32768;

  localparam int CFG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_CLIP_EN = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DRIVE   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_THRESH  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_MASTER  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_STEREO  = 3'd4;

  typedef struct packed {
    logic                 clip_en;
    logic [GAIN_BITS-1:0] drive;
    logic [GAIN_BITS-1:0] thr;
    logic [GAIN_BITS-1:0] master;
    logic                 stereo;
  } cfg_t;

  typedef struct packed {
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   ch;
    logic                   last;
  } item_t;

  typedef logic [TANH_ENTRIES-1:0][SAMPLE_BITS-1:0] tanh_tab_t;

  // shift-subtract quotient, only evaluated while the table is built
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(4i/N) = (1 - e^-x) / (1 + e^-x), e^-x stepped by products of a Q.60 series
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t   tab;
    logic [63:0] q60;
    logic [63:0] lo30;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    logic [63:0] mid;
    q60  = 64'd1 << 60;
    lo30 = (64'd1 << 30) - 64'd1;
    term = q60;
    r    = q60;
    e    = q60;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64(term * 64'd8, 64'(TANH_ENTRIES) * 64'(k));
      if ((k & 1) != 0) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      num    = (q60 - e) >> 30;
      den    = (q60 + e) >> 30;
      q      = udiv64((num << (SAMPLE_BITS - 1)) + (den >> 1), den);
      tab[i] = q[SAMPLE_BITS-1:0];
      ah     = e >> 30;
      al     = e & lo30;
      bh     = r >> 30;
      bl     = r & lo30;
      mid    = ah * bl + al * bh + ((al * bl) >> 30);
      e      = ah * bh + (mid >> 30);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

// ----- hw/rtl/sclp_ifs.sv -----
// Stream interfaces for the sample input and result output channels.
`timescale 1ns / 1ps
interface sclp_in_if;
  import sclp_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          channel;
  logic                          last_in_block;
  modport source (output valid, sample_in, channel, last_in_block, input ready);
  modport sink   (input valid, sample_in, channel, last_in_block, output ready);
endinterface

interface sclp_out_if;
  import sclp_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          channel_out;
  logic                          was_clipped;
  logic                          was_saturated;
  logic                          peak_valid;
  logic [SAMPLE_BITS-1:0]        peak_left_out;
  logic [SAMPLE_BITS-1:0]        peak_right_out;
  modport source (output valid, sample_out, channel_out, was_clipped, was_saturated,
                  peak_valid, peak_left_out, peak_right_out, input ready);
  modport sink   (input valid, sample_out, channel_out, was_clipped, was_saturated,
                  peak_valid, peak_left_out, peak_right_out, output ready);
endinterface

// ----- hw/rtl/sclp_regs.sv -----
// APB configuration registers.
`timescale 1ns / 1ps
module sclp_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sclp_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output sclp_pkg::cfg_t                      cfg
);
  import sclp_pkg::*;

  cfg_t                    cfg_r;
  cfg_t                    cfg_nxt;
  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_BITS-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_CLIP_EN: cfg_nxt.clip_en = pwdata[0];
        REG_DRIVE:   cfg_nxt.drive   = pwdata[GAIN_BITS-1:0];
        REG_THRESH:  cfg_nxt.thr     = pwdata[GAIN_BITS-1:0];
        REG_MASTER:  cfg_nxt.master  = pwdata[GAIN_BITS-1:0];
        REG_STEREO:  cfg_nxt.stereo  = pwdata[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CLIP_EN: prdata = {31'd0, cfg_r.clip_en};
      REG_DRIVE:   prdata = {16'd0, cfg_r.drive};
      REG_THRESH:  prdata = {16'd0, cfg_r.thr};
      REG_MASTER:  prdata = {16'd0, cfg_r.master};
      REG_STEREO:  prdata = {31'd0, cfg_r.stereo};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_en <= 1'b0;
      cfg_r.drive   <= 16'd4096;
      cfg_r.thr     <= THR_UNITY;
      cfg_r.master  <= 16'd16384;
      cfg_r.stereo  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/sclp_front.sv -----
// Input side: takes sample beats, splits sign and magnitude, queues them for the back end.
`timescale 1ns / 1ps
module sclp_front (
  input  logic            clk,
  input  logic            rst_n,
  sclp_in_if.sink         in_stream,
  output logic            q_valid,
  output sclp_pkg::item_t q_item,
  input  logic            q_pop
);
  import sclp_pkg::*;

  item_t                  q_mem [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r;
  logic [QPTR_BITS-1:0]   rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;
  logic                   push;
  logic                   pop;
  logic [SAMPLE_BITS-1:0] raw;
  item_t                  item_new;

  assign in_stream.ready = (count_r != QCNT_BITS'(QDEPTH));
  assign push            = in_stream.valid && in_stream.ready;
  assign q_valid         = (count_r != '0);
  assign pop             = q_pop && q_valid;
  assign q_item          = q_mem[rd_ptr_r];

  // the most negative code negates onto itself, which is exactly one as a magnitude
  always_comb begin
    raw           = in_stream.sample_in;
    item_new.neg  = raw[SAMPLE_BITS-1];
    item_new.mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    item_new.ch   = in_stream.channel;
    item_new.last = in_stream.last_in_block;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/sclp_back.sv -----
// Back end: sequencer around one shared multiplier for drive, curve, master gain and peak decay.
`timescale 1ns / 1ps
module sclp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sclp_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  sclp_pkg::item_t q_item,
  output logic            q_pop,
  sclp_out_if.source      out_stream
);
  import sclp_pkg::*;

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_DRV  = 4'd1;
  localparam logic [3:0] ST_THR  = 4'd2;
  localparam logic [3:0] ST_CMUL = 4'd3;
  localparam logic [3:0] ST_CADD = 4'd4;
  localparam logic [3:0] ST_MST  = 4'd5;
  localparam logic [3:0] ST_SAT  = 4'd6;
  localparam logic [3:0] ST_DECL = 4'd7;
  localparam logic [3:0] ST_DECR = 4'd8;
  localparam logic [3:0] ST_PKR  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0]             state_r;
  logic [PROD_BITS-1:0]   prod_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic                   neg_r;
  logic                   ch_r;
  logic                   last_r;
  logic                   clip_r;
  logic                   sat_r;
  logic [SAMPLE_BITS-1:0] th_r;
  logic [SAMPLE_BITS-1:0] bml_r;
  logic [SAMPLE_BITS-1:0] bmr_r;
  logic [SAMPLE_BITS-1:0] pkl_r;
  logic [SAMPLE_BITS-1:0] pkr_r;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic                   out_ch_r;
  logic                   out_clip_r;
  logic                   out_sat_r;
  logic                   out_pv_r;
  logic [SAMPLE_BITS-1:0] out_pkl_r;
  logic [SAMPLE_BITS-1:0] out_pkr_r;

  logic [SAMPLE_BITS-1:0] mul_a;
  logic [SAMPLE_BITS-1:0] mul_b;
  logic [SAMPLE_BITS-1:0] thr_t;
  logic [ACC_BITS-1:0]    drv_a;
  logic [ACC_BITS-1:0]    excess;
  logic                   over;
  logic [SAMPLE_BITS-1:0] th_sel;
  logic [SAMPLE_BITS-1:0] curve_sum;
  logic [MST_BITS-1:0]    mst_m;
  logic [SAMPLE_BITS-1:0] sat_lim;
  logic                   sat_hit;
  logic [SAMPLE_BITS-1:0] mag_sat;
  logic [SAMPLE_BITS-1:0] decay;
  logic [SAMPLE_BITS-1:0] mono_r_max;
  logic                   out_free;
  logic                   to_left;

  assign out_free = !out_valid_r || out_stream.ready;
  assign q_pop    = (state_r == ST_LOAD) && q_valid;
  assign to_left  = !cfg.stereo || !ch_r;

  always_comb begin
    if (cfg.thr > THR_UNITY) begin
      thr_t = S_ONE;
    end else begin
      thr_t = SAMPLE_BITS'(cfg.thr) << THR_SHIFT;
    end
  end

  always_comb begin
    drv_a  = prod_r[DRIVE_FRAC +: ACC_BITS];
    over   = drv_a > ACC_BITS'(thr_t);
    excess = drv_a - ACC_BITS'(thr_t);
    if (excess[ACC_BITS-1:IDX_SHIFT+TANH_IDX_BITS] != '0) begin
      th_sel = S_ONE;
    end else begin
      th_sel = TANH_TAB[excess[IDX_SHIFT +: TANH_IDX_BITS]];
    end
    curve_sum = thr_t + prod_r[SAMPLE_BITS-1 +: SAMPLE_BITS];
    mst_m     = prod_r[MASTER_FRAC +: MST_BITS];
    sat_lim   = neg_r ? S_ONE : (S_ONE - 1'b1);
    sat_hit   = mst_m > MST_BITS'(sat_lim);
    mag_sat   = sat_hit ? sat_lim : mst_m[SAMPLE_BITS-1:0];
    decay     = prod_r[DECAY_FRAC +: SAMPLE_BITS];
    mono_r_max = cfg.stereo ? bmr_r : bml_r;
  end

  always_comb begin
    case (state_r)
      ST_DRV:  begin
        mul_a = mag_r;
        mul_b = SAMPLE_BITS'(cfg.drive);
      end
      ST_CMUL: begin
        mul_a = S_ONE - thr_t;
        mul_b = th_r;
      end
      ST_MST:  begin
        mul_a = mag_r;
        mul_b = SAMPLE_BITS'(cfg.master);
      end
      ST_DECL: begin
        mul_a = pkl_r;
        mul_b = SAMPLE_BITS'(DECAY_Q16);
      end
      ST_DECR: begin
        mul_a = pkr_r;
        mul_b = SAMPLE_BITS'(DECAY_Q16);
      end
      default: begin
        mul_a = mag_r;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        if (q_valid) begin
          mag_r  <= q_item.mag;
          neg_r  <= q_item.neg;
          ch_r   <= q_item.ch;
          last_r <= q_item.last;
          clip_r <= 1'b0;
          sat_r  <= 1'b0;
        end
      end
      ST_THR: begin
        if (over) begin
          th_r   <= th_sel;
          clip_r <= 1'b1;
        end else begin
          mag_r <= drv_a[SAMPLE_BITS-1:0];
        end
      end
      ST_CADD: mag_r <= curve_sum;
      ST_SAT: begin
        mag_r <= mag_sat;
        sat_r <= sat_hit;
      end
      default: mag_r <= mag_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      bml_r       <= '0;
      bmr_r       <= '0;
      pkl_r       <= '0;
      pkr_r       <= '0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (q_valid) begin
            state_r <= cfg.clip_en ? ST_DRV : ST_MST;
          end
        end
        ST_DRV:  state_r <= ST_THR;
        ST_THR:  state_r <= over ? ST_CMUL : ST_MST;
        ST_CMUL: state_r <= ST_CADD;
        ST_CADD: state_r <= ST_MST;
        ST_MST:  state_r <= ST_SAT;
        ST_SAT: begin
          if (to_left) begin
            if (mag_sat > bml_r) begin
              bml_r <= mag_sat;
            end
          end else begin
            if (mag_sat > bmr_r) begin
              bmr_r <= mag_sat;
            end
          end
          state_r <= last_r ? ST_DECL : ST_OUT;
        end
        ST_DECL: state_r <= ST_DECR;
        ST_DECR: begin
          pkl_r   <= (bml_r > decay) ? bml_r : decay;
          state_r <= ST_PKR;
        end
        ST_PKR: begin
          pkr_r   <= (mono_r_max > decay) ? mono_r_max : decay;
          bml_r   <= '0;
          bmr_r   <= '0;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_sample_r <= neg_r ? (~mag_r + 1'b1) : mag_r;
      out_ch_r     <= ch_r;
      out_clip_r   <= clip_r;
      out_sat_r    <= sat_r;
      out_pv_r     <= last_r;
      out_pkl_r    <= pkl_r;
      out_pkr_r    <= pkr_r;
    end
  end

  assign out_stream.valid          = out_valid_r;
  assign out_stream.sample_out     = out_sample_r;
  assign out_stream.channel_out    = out_ch_r;
  assign out_stream.was_clipped    = out_clip_r;
  assign out_stream.was_saturated  = out_sat_r;
  assign out_stream.peak_valid     = out_pv_r;
  assign out_stream.peak_left_out  = out_pkl_r;
  assign out_stream.peak_right_out = out_pkr_r;

  a_peaks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (pkl_r <= S_ONE) && (pkr_r <= S_ONE))
    else $error("peak above full scale");

  a_mag_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MST) |-> (mag_r <= S_ONE))
    else $error("magnitude above one before master gain");

  a_blockmax_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PKR) |=> (bml_r == '0) && (bmr_r == '0))
    else $error("block maxima not cleared at block end");

  a_clip_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && clip_r) |-> cfg.clip_en)
    else $error("clip flagged while clipping is bypassed");

endmodule

// ----- hw/rtl/soft_clip_gain_peak_meter.sv -----
// Top level: soft clipper with drive, master gain and per-channel block peak meter.
//
// Usage:
//   in_stream  carries one audio sample beat (sample_in, channel, last_in_block),
//              accepted when valid and ready are both high.
//   out_stream returns exactly one result beat per input beat, in order.
//   cfg_*      APB port; registers at byte offsets 0x00 clip_enable, 0x04 drive_gain,
//              0x08 clip_threshold_gain, 0x0C master_gain, 0x10 stereo_enable.
//              Write only while no beat is in flight.
// Sequencing: the back-end sequencer owns a single 24x24 multiplier and steps each beat
//   through load, drive and threshold (clipping enabled only), curve multiply and add
//   (threshold crossing only), master gain, saturation, the two peak decay products and
//   peak update (block-end beat only), then output.
// A two-entry queue sits between input and sequencer and the result has its own output
//   register, so input keeps flowing while a finished result waits on a stalled receiver;
//   whenever the queue holds two beats, in_stream.ready drops.
// Reset (rst_n low, synchronous) empties the queue, clears the peaks and block maxima,
//   and loads register defaults.
`timescale 1ns / 1ps
module soft_clip_gain_peak_meter (
  input  logic                               clk,
  input  logic                               rst_n,
  sclp_in_if.sink                            in_stream,
  sclp_out_if.source                         out_stream,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sclp_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import sclp_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  sclp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sclp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  sclp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule
